// File: sv/glc_pkg.sv
// Package for the glyph slot LRU cache: entry type, codes and
// configuration constants. No dependencies.
`timescale 1ns / 1ps

package glc_pkg;

   // Field widths
   localparam int CODE_W  = 16;
   localparam int SLOT_W  = 8;
   localparam int CFG_W   = 8;
   localparam int CSR_IDX_W = 3;

   // Code that marks an empty entry
   localparam logic [CODE_W-1:0] EMPTY_CODE = 16'hFFFF;

   // Request function codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INIT   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_CAP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_SPLIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BASE    = 3'd4;

   // Configuration reset values
   localparam logic [CFG_W-1:0] RST_ENTRY_COUNT  = 8'd100;
   localparam logic [CFG_W-1:0] RST_SEARCH_CAP   = 8'd50;
   localparam logic             RST_LAYER_ENABLE = 1'b1;
   localparam logic [CFG_W-1:0] RST_LAYER_SPLIT  = 8'd50;
   localparam logic [CFG_W-1:0] RST_SLOT_BASE    = 8'd0;

   // One table entry
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              layer;
      logic [SLOT_W-1:0] slot;
   } entry_type;

endpackage

// File: sv/glyph_slot_lru_cache_unit.sv
// Glyph slot LRU cache top level: sequencer, entry memory and config.
// Depends on glc_pkg.
`timescale 1ns / 1ps

// Maps 16-bit character codes to display slots, kept in move-to-front
// order in a single-port-read entry memory. A lookup found at table
// position p (hit, first empty entry, or last searched entry) is answered
// after a read and a compare for each entry up to p, a read and a write
// for each entry shifted back, a write of the front entry and a load of
// the output register; each entry is read in turn through the single read
// port of the entry memory. An init request rewrites all TABLE_DEPTH entries,
// one a cycle, and answers with slot, layer and hit all zero. After reset
// the block runs the same fill with the reset settings and takes no
// request until it is done; configuration writes are taken at any time.
// One request is in work at a time; a finished result waits in the output
// register.
module glyph_slot_lru_cache_unit #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [glc_pkg::CODE_W-1:0]    req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [glc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_layer,
   output logic                          rsp_hit,
   input  logic                          csr_wr_en,
   input  logic [glc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [glc_pkg::CFG_W-1:0]     csr_wr_data
);
   import glc_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [8:0]       DEPTH9   = 9'(TABLE_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CLEAR    = 8'b0000_0010,
      S_READ     = 8'b0000_0100,
      S_CMP      = 8'b0000_1000,
      S_SHIFT_RD = 8'b0001_0000,
      S_SHIFT_WR = 8'b0010_0000,
      S_FRONT    = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   // Configuration registers
   logic [CFG_W-1:0] entry_count_ff, search_cap_ff, layer_split_ff, slot_base_ff;
   logic             layer_enable_ff;

   // Sequencer state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] sav_slot_ff, sav_slot_in;
   logic              sav_layer_ff, sav_layer_in;
   logic              clr_rpt_ff, clr_rpt_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_layer_ff, rsp_layer_in;
   logic              rsp_hit_ff, rsp_hit_in;

   // Entry memory
   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // Search length and init entry helpers
   logic [8:0]       len;
   logic [8:0]       fill_i9, fill_split9, fill_base9, fill_slot9;
   logic [CFG_W-1:0] fill_split, fill_base;
   entry_type        fill_entry;
   logic             req_take;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_layer = rsp_layer_ff;
   assign rsp_hit   = rsp_hit_ff;

   // Clip the search length to the depth, to the cap when layers are disabled, and to a minimum of one
   always_comb begin
      len = {1'b0, entry_count_ff};
      if (len > DEPTH9) begin
         len = DEPTH9;
      end
      if (!layer_enable_ff && (len > {1'b0, search_cap_ff})) begin
         len = {1'b0, search_cap_ff};
      end
      if (len == 9'd0) begin
         len = 9'd1;
      end
   end

   // Build the init entry for the sweep position; reset pass uses reset values
   always_comb begin
      fill_split  = clr_rpt_ff ? layer_split_ff : RST_LAYER_SPLIT;
      fill_base   = clr_rpt_ff ? slot_base_ff : RST_SLOT_BASE;
      fill_i9     = 9'(idx_ff);
      fill_split9 = {1'b0, fill_split};
      fill_base9  = {1'b0, fill_base};
      fill_entry.code = EMPTY_CODE;
      if (fill_i9 < fill_split9) begin
         fill_entry.layer = 1'b0;
         fill_slot9       = fill_base9 + fill_i9;
      end else begin
         fill_entry.layer = 1'b1;
         fill_slot9       = fill_base9 + fill_i9 - fill_split9;
      end
      fill_entry.slot = fill_slot9[SLOT_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      code_in      = code_ff;
      hit_in       = hit_ff;
      sav_slot_in  = sav_slot_ff;
      sav_layer_in = sav_layer_ff;
      clr_rpt_in   = clr_rpt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_layer_in = rsp_layer_ff;
      rsp_hit_in   = rsp_hit_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = fill_entry;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               idx_in  = '0;
               code_in = req_char_code;
               if (req_func == FUNC_INIT) begin
                  hit_in       = 1'b0;
                  sav_slot_in  = '0;
                  sav_layer_in = 1'b0;
                  clr_rpt_in   = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  last_in  = IDX_W'(len - 9'd1);
                  state_in = S_READ;
               end
            end
         end
         S_CLEAR: begin
            // write one init entry a cycle
            wr_en = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = clr_rpt_ff ? S_FINISH : S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            // hit first, then empty entry, then end of the search
            if ((rd_data_ff.code == code_ff) || (rd_data_ff.code == EMPTY_CODE) ||
                (idx_ff == last_ff)) begin
               hit_in       = (rd_data_ff.code == code_ff);
               sav_slot_in  = rd_data_ff.slot;
               sav_layer_in = rd_data_ff.layer;
               state_in     = (idx_ff == '0) ? S_FRONT : S_SHIFT_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_SHIFT_RD: begin
            rd_addr  = idx_ff - IDX_W'(1);
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move the entry ahead back by one place
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - IDX_W'(1);
            state_in = (idx_ff == IDX_W'(1)) ? S_FRONT : S_SHIFT_RD;
         end
         S_FRONT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.code  = code_ff;
            wr_data.layer = sav_layer_ff;
            wr_data.slot  = sav_slot_ff;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = sav_slot_ff;
               rsp_layer_in = sav_layer_ff;
               rsp_hit_in   = hit_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         clr_rpt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rpt_ff   <= clr_rpt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      code_ff      <= code_in;
      hit_ff       <= hit_in;
      sav_slot_ff  <= sav_slot_in;
      sav_layer_ff <= sav_layer_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_layer_ff <= rsp_layer_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= RST_ENTRY_COUNT;
         search_cap_ff   <= RST_SEARCH_CAP;
         layer_enable_ff <= RST_LAYER_ENABLE;
         layer_split_ff  <= RST_LAYER_SPLIT;
         slot_base_ff    <= RST_SLOT_BASE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENTRY_COUNT:  entry_count_ff  <= csr_wr_data;
            CSR_SEARCH_CAP:   search_cap_ff   <= csr_wr_data;
            CSR_LAYER_ENABLE: layer_enable_ff <= csr_wr_data[0];
            CSR_LAYER_SPLIT:  layer_split_ff  <= csr_wr_data;
            CSR_SLOT_BASE:    slot_base_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// File: sv/glc_checker.sv
// Port-level checks for the glyph slot LRU cache, bound to the top level.
// Depends on glc_pkg for field widths.
`timescale 1ns / 1ps

module glc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [glc_pkg::SLOT_W-1:0]    rsp_slot,
   input logic                          rsp_layer,
   input logic                          rsp_hit
);
   import glc_pkg::*;

   // Hold off requests and results right after reset, as the fill pass starts
   a_reset_fill: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("request or result during reset fill");

   // Drop ready once a request is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a request was taken");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_slot) && $stable(rsp_layer) && $stable(rsp_hit)))
      else $error("stalled result changed");

endmodule

bind glyph_slot_lru_cache_unit glc_checker u_glc_checker (.*);
